// File: sv/clmp_pkg.sv
// Shared types and constants of the CPU list parser.
// Depends on nothing; every other file of the block but clmp_ram refers to it by scoped names.
package clmp_pkg;

    // Fixed field widths of the ports.
    localparam int LIMIT_W  = 11;
    localparam int CHAR_W   = 8;
    localparam int COUNT_W  = 11;
    localparam int HIGH_W   = 10;
    localparam int WIDX_W   = 4;
    localparam int MASK_W   = 64;
    localparam int WSHIFT   = 6;

    // CPU ids carried between the parser and the mask engine (ids stay below 4096).
    localparam int CMD_ID_W = 12;

    // Depth of the command queue between the two halves.
    localparam int CMDQ_DEPTH = 4;

    // Result status codes; the two error codes double as the parser's error codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_NONE  = 2'd3;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'd44;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

    // One input request: a byte of text and the end-of-string mark.
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } in_t;

    // One result request: one mask word with the string's status.
    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] cpu_count;
        logic [HIGH_W-1:0]  highest_cpu;
        logic [WIDX_W-1:0]  word_index;
        logic [MASK_W-1:0]  mask_word;
        logic               last_result;
    } out_t;

    // Command from the parser to the mask engine: an optional range to set,
    // optionally followed by the end of the string.
    typedef struct packed {
        logic                rng_valid;
        logic [CMD_ID_W-1:0] lo;
        logic [CMD_ID_W-1:0] hi;
        logic                end_valid;
        logic [1:0]          status;
        logic [CMD_ID_W-1:0] highest;
    } cmd_t;

    // Number of set bits in one byte.
    function automatic logic [3:0] popcount8(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'd0, b[i]};
        end
        return n;
    endfunction

endpackage

// File: sv/clmp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the mask word store.
module clmp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/clmp_front.sv
// Parser half: classifies each byte, accumulates numbers, checks each finished range
// and queues range and end-of-string commands. Depends on clmp_pkg.
module clmp_front #(
    parameter int MAX_CPUS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [clmp_pkg::LIMIT_W-1:0] cfg_data,
    input  logic                         in_valid,
    input  clmp_pkg::in_t                item,
    output logic                         cmd_push,
    output clmp_pkg::cmd_t               cmd
);

    localparam int VW      = $clog2(MAX_CPUS + 1);
    localparam int HW      = $clog2(MAX_CPUS);
    localparam int CLW     = (VW > clmp_pkg::LIMIT_W) ? VW : clmp_pkg::LIMIT_W;
    localparam int LIM_RST = (MAX_CPUS < 1024) ? MAX_CPUS : 1024;
    localparam logic [VW-1:0] VMAX = VW'(MAX_CPUS);

    // Parse phases.
    localparam logic [2:0] PH_SKIP  = 3'd0;
    localparam logic [2:0] PH_FSIGN = 3'd1;
    localparam logic [2:0] PH_FDIG  = 3'd2;
    localparam logic [2:0] PH_SWS   = 3'd3;
    localparam logic [2:0] PH_SSIGN = 3'd4;
    localparam logic [2:0] PH_SDIG  = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;

    logic [VW-1:0] lim_reg, lim_next;
    logic [2:0]    phase_reg, phase_next;
    logic [VW-1:0] fv_reg, fv_next;
    logic [VW-1:0] sv_reg, sv_next;
    logic          fn_reg, fn_next;
    logic          sn_reg, sn_next;
    logic [1:0]    err_reg, err_next;
    logic          found_reg, found_next;
    logic [HW-1:0] high_reg, high_next;

    logic [CLW-1:0] cfg_ext;

    // Byte classes.
    logic [clmp_pkg::CHAR_W-1:0] c;
    logic          is_sp, is_dig, is_sign, is_minus, is_comma;
    logic [VW-1:0] dval;

    // What a token-start byte does from the separator phase.
    logic [2:0]    sk_ph;
    logic [VW-1:0] sk_fv;
    logic          sk_fn, sk_inv;

    // First step (this byte).
    logic [2:0]    ph1;
    logic [VW-1:0] fv1, sv1;
    logic          fn1, sn1, inv1, fire1, two1;

    // Implied terminator step on the last byte.
    logic          fire2, two2;

    // Token check.
    logic          fire, two;
    logic [VW-1:0] ta, tb, lo, hi;
    logic          tan, tbn, t_inv, t_rng, t_ok;

    // Outcome of the whole request.
    logic [2:0]    ph_f;
    logic [1:0]    e_f, err_f, status_f;
    logic [VW-1:0] fv_f;
    logic          fn_f, found_f;
    logic [HW-1:0] high_f;

    // Multiply by ten and add a digit, saturating at the CPU count.
    function automatic logic [VW-1:0] acc(input logic [VW-1:0] v, input logic [3:0] d);
        logic [VW+3:0] n;
        n = ((VW+4)'(v) << 3) + ((VW+4)'(v) << 1) + (VW+4)'(d);
        return (n >= (VW+4)'(MAX_CPUS)) ? VMAX : VW'(n);
    endfunction

    // Limit register, clamped to the mask size on write.
    assign cfg_ext  = CLW'(cfg_data);
    assign lim_next = (cfg_ext > CLW'(MAX_CPUS)) ? VMAX : VW'(cfg_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= VW'(LIM_RST);
        end
        else if (cfg_we)
        begin
            lim_reg <= lim_next;
        end
    end

    // Byte classification.
    assign c        = item.char_code;
    assign is_sp    = (c == clmp_pkg::CH_SPACE) ||
                      ((c >= clmp_pkg::CH_TAB) && (c <= clmp_pkg::CH_CR));
    assign is_dig   = (c >= clmp_pkg::CH_ZERO) && (c <= clmp_pkg::CH_NINE);
    assign is_minus = (c == clmp_pkg::CH_MINUS);
    assign is_sign  = (c == clmp_pkg::CH_PLUS) || is_minus;
    assign is_comma = (c == clmp_pkg::CH_COMMA);
    assign dval     = VW'(c[3:0]);

    // Separator phase behavior of this byte.
    always_comb
    begin
        sk_ph  = PH_SKIP;
        sk_fv  = is_dig ? dval : '0;
        sk_fn  = is_minus;
        sk_inv = 1'b0;
        priority if (is_sp || is_comma)
        begin
            sk_ph = PH_SKIP;
        end
        else if (c == clmp_pkg::CH_NUL)
        begin
            sk_ph = PH_DONE;
        end
        else if (is_dig)
        begin
            sk_ph = PH_FDIG;
        end
        else if (is_sign)
        begin
            sk_ph = PH_FSIGN;
        end
        else
        begin
            sk_inv = 1'b1;
        end
    end

    // First step: the byte itself against the current phase.
    always_comb
    begin
        ph1   = phase_reg;
        fv1   = fv_reg;
        sv1   = sv_reg;
        fn1   = fn_reg;
        sn1   = sn_reg;
        inv1  = 1'b0;
        fire1 = 1'b0;
        two1  = 1'b0;
        unique case (phase_reg)
            PH_SKIP:
            begin
                if (sk_inv)
                begin
                    inv1 = 1'b1;
                end
                else
                begin
                    ph1 = sk_ph;
                    fv1 = sk_fv;
                    fn1 = sk_fn;
                end
            end
            PH_FSIGN:
            begin
                if (is_dig)
                begin
                    fv1 = dval;
                    ph1 = PH_FDIG;
                end
                else
                begin
                    inv1 = 1'b1;
                end
            end
            PH_FDIG:
            begin
                priority if (is_dig)
                begin
                    fv1 = acc(fv_reg, c[3:0]);
                end
                else if (is_minus)
                begin
                    sv1 = '0;
                    sn1 = 1'b0;
                    ph1 = PH_SWS;
                end
                else
                begin
                    fire1 = 1'b1;
                    ph1   = PH_SKIP;
                end
            end
            PH_SWS:
            begin
                priority if (is_sp)
                begin
                    ph1 = PH_SWS;
                end
                else if (is_dig)
                begin
                    sv1 = dval;
                    ph1 = PH_SDIG;
                end
                else if (is_sign)
                begin
                    sn1 = is_minus;
                    ph1 = PH_SSIGN;
                end
                else
                begin
                    inv1 = 1'b1;
                end
            end
            PH_SSIGN:
            begin
                if (is_dig)
                begin
                    sv1 = dval;
                    ph1 = PH_SDIG;
                end
                else
                begin
                    inv1 = 1'b1;
                end
            end
            PH_SDIG:
            begin
                if (is_dig)
                begin
                    sv1 = acc(sv_reg, c[3:0]);
                end
                else
                begin
                    fire1 = 1'b1;
                    two1  = 1'b1;
                    ph1   = PH_SKIP;
                end
            end
            default:
            begin
                ph1 = PH_DONE;
            end
        endcase
        if (inv1)
        begin
            ph1 = PH_DONE;
        end
    end

    // A number still open at the last byte is closed by the implied terminator.
    assign fire2 = item.last_char && !fire1 && !inv1 && ((ph1 == PH_FDIG) || (ph1 == PH_SDIG));
    assign two2  = (ph1 == PH_SDIG);

    // Token check: at most one token closes per request.
    assign fire  = fire1 || fire2;
    assign two   = fire1 ? two1 : two2;
    assign ta    = fv1;
    assign tan   = fn1;
    assign tb    = two ? sv1 : fv1;
    assign tbn   = two ? sn1 : fn1;
    assign lo    = (ta < tb) ? ta : tb;
    assign hi    = (ta < tb) ? tb : ta;
    assign t_inv = (tan && (ta != '0)) || (tbn && (tb != '0));
    assign t_rng = (hi >= lim_reg);
    assign t_ok  = fire && !t_inv && !t_rng;

    // Final phase, error and token bookkeeping for this request.
    always_comb
    begin
        ph_f = ph1;
        e_f  = clmp_pkg::ST_OK;
        fv_f = fv1;
        fn_f = fn1;
        priority if (inv1)
        begin
            e_f  = clmp_pkg::ST_INVAL;
            ph_f = PH_DONE;
        end
        else if (fire)
        begin
            priority if (t_inv)
            begin
                e_f  = clmp_pkg::ST_INVAL;
                ph_f = PH_DONE;
            end
            else if (t_rng)
            begin
                e_f  = clmp_pkg::ST_RANGE;
                ph_f = PH_DONE;
            end
            else if (fire1)
            begin
                // The byte that closed the token may start the next one.
                if (sk_inv)
                begin
                    e_f  = clmp_pkg::ST_INVAL;
                    ph_f = PH_DONE;
                end
                else
                begin
                    ph_f = sk_ph;
                    fv_f = sk_fv;
                    fn_f = sk_fn;
                    if (item.last_char && (sk_ph == PH_FSIGN))
                    begin
                        e_f = clmp_pkg::ST_INVAL;
                    end
                    if (item.last_char)
                    begin
                        ph_f = PH_DONE;
                    end
                end
            end
            else
            begin
                ph_f = PH_DONE;
            end
        end
        else if (item.last_char && (ph1 != PH_DONE))
        begin
            // A dangling sign or range dash is invalid at the end.
            if (ph1 != PH_SKIP)
            begin
                e_f = clmp_pkg::ST_INVAL;
            end
            ph_f = PH_DONE;
        end
    end

    assign err_f    = (e_f != clmp_pkg::ST_OK) ? e_f : err_reg;
    assign found_f  = found_reg || t_ok;
    assign high_f   = (t_ok && (hi > VW'(high_reg))) ? HW'(hi) : high_reg;
    assign status_f = (err_f != clmp_pkg::ST_OK) ? err_f :
                      (found_f ? clmp_pkg::ST_OK : clmp_pkg::ST_NONE);

    // Next state: the end of a string returns everything to its reset value.
    always_comb
    begin
        phase_next = phase_reg;
        fv_next    = fv_reg;
        sv_next    = sv_reg;
        fn_next    = fn_reg;
        sn_next    = sn_reg;
        err_next   = err_reg;
        found_next = found_reg;
        high_next  = high_reg;
        if (in_valid)
        begin
            if (item.last_char)
            begin
                phase_next = PH_SKIP;
                fv_next    = '0;
                sv_next    = '0;
                fn_next    = 1'b0;
                sn_next    = 1'b0;
                err_next   = clmp_pkg::ST_OK;
                found_next = 1'b0;
                high_next  = '0;
            end
            else
            begin
                phase_next = ph_f;
                fv_next    = fv_f;
                sv_next    = sv1;
                fn_next    = fn_f;
                sn_next    = sn1;
                err_next   = err_f;
                found_next = found_f;
                high_next  = high_f;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            fv_reg    <= '0;
            sv_reg    <= '0;
            fn_reg    <= 1'b0;
            sn_reg    <= 1'b0;
            err_reg   <= clmp_pkg::ST_OK;
            found_reg <= 1'b0;
            high_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fv_reg    <= fv_next;
            sv_reg    <= sv_next;
            fn_reg    <= fn_next;
            sn_reg    <= sn_next;
            err_reg   <= err_next;
            found_reg <= found_next;
            high_reg  <= high_next;
        end
    end

    // Command out: a range that passed its checks and/or the end of the string.
    assign cmd_push      = in_valid && (t_ok || item.last_char);
    assign cmd.rng_valid = t_ok;
    assign cmd.lo        = clmp_pkg::CMD_ID_W'(lo);
    assign cmd.hi        = clmp_pkg::CMD_ID_W'(hi);
    assign cmd.end_valid = item.last_char;
    assign cmd.status    = status_f;
    assign cmd.highest   = clmp_pkg::CMD_ID_W'(high_f);

endmodule

// File: sv/clmp_cmdq.sv
// Short command queue between the parser and the mask engine.
// Depends on clmp_pkg for the command type and the queue depth.
module clmp_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  clmp_pkg::cmd_t din,
    output logic           full,
    input  logic           pop,
    output clmp_pkg::cmd_t dout,
    output logic           empty
);

    localparam int DEPTH = clmp_pkg::CMDQ_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    clmp_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW-1:0]  rptr_reg, rptr_next;
    logic [PW:0]    cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign full    = (cnt_reg == (PW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rptr_reg];

    // Pointer and fill bookkeeping with wraparound at the queue depth.
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + (PW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

// File: sv/clmp_back.sv
// Mask engine: sets range bits word by word in the mask RAM, counts new bits,
// and streams the mask out at the end of a string. Depends on clmp_pkg, clmp_ram.
module clmp_back #(
    parameter int MAX_CPUS = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_empty,
    input  clmp_pkg::cmd_t cmd,
    output logic           cmd_pop,
    input  logic           pop,
    output logic           empty,
    output clmp_pkg::out_t result
);

    localparam int WORDS = (MAX_CPUS + 63) / 64;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = $clog2(MAX_CPUS + 1);
    localparam int MW    = clmp_pkg::MASK_W;

    // Engine states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_ORD   = 3'd3;
    localparam logic [2:0] S_OEMIT = 3'd4;
    localparam logic [2:0] S_ERR   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [AW-1:0]    w_reg, w_next;
    logic             done_reg, done_next;
    logic             pend_reg, pend_next;
    logic             rvalid_reg, rvalid_next;
    logic [WORDS-1:0] wvalid_reg, wvalid_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             ovalid_reg, ovalid_next;
    clmp_pkg::out_t   ores_reg, ores_next;
    logic [3:0]       bcnt_reg [8];
    logic [3:0]       bcnt_next [8];

    logic             ram_we, ram_re;
    logic [MW-1:0]    rdata, old, m, newbits;
    logic [AW-1:0]    wlo, whi;
    logic [5:0]       bl, bh;
    logic [6:0]       bsum;
    logic             oload, clear, is_last;

    clmp_ram #(
        .WIDTH (MW),
        .DEPTH (WORDS)
    ) u_mask_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (w_reg),
        .wdata (old | m),
        .re    (ram_re),
        .raddr (w_reg),
        .rdata (rdata)
    );

    // Word span and bit mask of the range for the current word.
    assign wlo     = AW'(cmd.lo[clmp_pkg::CMD_ID_W-1:clmp_pkg::WSHIFT]);
    assign whi     = AW'(cmd.hi[clmp_pkg::CMD_ID_W-1:clmp_pkg::WSHIFT]);
    assign bl      = (w_reg == wlo) ? cmd.lo[5:0] : 6'd0;
    assign bh      = (w_reg == whi) ? cmd.hi[5:0] : 6'd63;
    assign m       = ({MW{1'b1}} << bl) & ({MW{1'b1}} >> (6'd63 - bh));
    assign old     = rvalid_reg ? rdata : '0;
    assign newbits = m & ~old;
    assign is_last = (w_reg == AW'(WORDS - 1));
    assign oload   = !ovalid_reg || pop;

    // Sum of the byte counts of the previous word's new bits.
    always_comb
    begin
        bsum = 7'd0;
        for (int i = 0; i < 8; i++)
        begin
            bsum = bsum + {3'd0, bcnt_reg[i]};
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            bcnt_next[i] = clmp_pkg::popcount8(newbits[8*i +: 8]);
        end
    end

    // Engine control.
    always_comb
    begin
        state_next  = state_reg;
        w_next      = w_reg;
        done_next   = done_reg;
        pend_next   = 1'b0;
        rvalid_next = rvalid_reg;
        wvalid_next = wvalid_reg;
        ores_next   = ores_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        cmd_pop     = 1'b0;
        clear       = 1'b0;
        ovalid_next = ovalid_reg && !pop;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    priority if (cmd.rng_valid && !done_reg)
                    begin
                        w_next     = wlo;
                        state_next = S_RD;
                    end
                    else if (cmd.end_valid)
                    begin
                        w_next     = '0;
                        state_next = (cmd.status == clmp_pkg::ST_OK) ? S_ORD : S_ERR;
                    end
                    else
                    begin
                        cmd_pop   = 1'b1;
                        done_next = 1'b0;
                    end
                end
            end
            S_RD:
            begin
                ram_re      = 1'b1;
                rvalid_next = wvalid_reg[w_reg];
                state_next  = S_MOD;
            end
            S_MOD:
            begin
                ram_we             = 1'b1;
                wvalid_next[w_reg] = 1'b1;
                pend_next          = 1'b1;
                if (w_reg == whi)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    w_next     = w_reg + AW'(1);
                    state_next = S_RD;
                end
            end
            S_ORD:
            begin
                ram_re      = 1'b1;
                rvalid_next = wvalid_reg[w_reg];
                state_next  = S_OEMIT;
            end
            S_OEMIT:
            begin
                if (oload)
                begin
                    ovalid_next           = 1'b1;
                    ores_next.status      = clmp_pkg::ST_OK;
                    ores_next.cpu_count   = clmp_pkg::COUNT_W'(cnt_reg);
                    ores_next.highest_cpu = clmp_pkg::HIGH_W'(cmd.highest);
                    ores_next.word_index  = clmp_pkg::WIDX_W'(w_reg);
                    ores_next.mask_word   = old;
                    ores_next.last_result = is_last;
                    if (is_last)
                    begin
                        clear      = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        w_next     = w_reg + AW'(1);
                        state_next = S_ORD;
                    end
                end
            end
            S_ERR:
            begin
                if (oload)
                begin
                    ovalid_next           = 1'b1;
                    ores_next.status      = cmd.status;
                    ores_next.cpu_count   = '0;
                    ores_next.highest_cpu = '0;
                    ores_next.word_index  = '0;
                    ores_next.mask_word   = '0;
                    ores_next.last_result = 1'b1;
                    clear                 = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // End of string: release the command and forget the whole mask at once.
        if (clear)
        begin
            cmd_pop     = 1'b1;
            done_next   = 1'b0;
            wvalid_next = '0;
        end
    end

    // Count of distinct CPUs set so far in this string.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (clear)
        begin
            cnt_next = '0;
        end
        else if (pend_reg)
        begin
            cnt_next = cnt_reg + CW'(bsum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            w_reg      <= '0;
            done_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            rvalid_reg <= 1'b0;
            wvalid_reg <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            w_reg      <= w_next;
            done_reg   <= done_next;
            pend_reg   <= pend_next;
            rvalid_reg <= rvalid_next;
            wvalid_reg <= wvalid_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ores_reg <= ores_next;
        bcnt_reg <= bcnt_next;
    end

    assign empty  = !ovalid_reg;
    assign result = ores_reg;

endmodule

// File: sv/cpu_list_to_mask_parser.sv
// Top level of the CPU list parser: parser half, command queue and mask engine.
// Depends on clmp_pkg, clmp_front, clmp_cmdq, clmp_back and clmp_ram.

// Feed a CPU list such as "0-3,8" one byte per request, with last_char on the final
// byte; a zero byte ends the parse early. The parser takes one byte per cycle while
// its four-entry command queue has room, so full rises only when the mask engine
// falls behind. The engine dispatches each command and, for each 64-bit mask word a
// range touches, reads the word from RAM, then writes it back merged. On the final
// byte it returns one result per mask word ((MAX_CPUS+63)/64 of them, each read and
// then emitted through the single read port of the mask RAM) when the list is
// valid, or a single error or none-found result. The mask needs no clearing pass:
// per-word valid bits drop at the end of each string, so the block is ready right
// after reset. The cpu_limit register (cfg_data, clamped to MAX_CPUS) may be
// written only while the block is idle.
module cpu_list_to_mask_parser #(
    parameter int MAX_CPUS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  clmp_pkg::in_t                item,
    output logic                         full,
    input  logic                         pop,
    output clmp_pkg::out_t               result,
    output logic                         empty,
    input  logic                         cfg_we,
    input  logic [clmp_pkg::LIMIT_W-1:0] cfg_data
);

    logic           in_valid;
    logic           q_push, q_pop, q_empty;
    clmp_pkg::cmd_t q_din, q_dout;

    assign in_valid = push && !full;

    // Parser half.
    clmp_front #(
        .MAX_CPUS (MAX_CPUS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .item     (item),
        .cmd_push (q_push),
        .cmd      (q_din)
    );

    // Command queue.
    clmp_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    // Mask engine and result register.
    clmp_back #(
        .MAX_CPUS (MAX_CPUS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (q_empty),
        .cmd       (q_dout),
        .cmd_pop   (q_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

// File: sv/clmp_checker.sv
// Port-level checks of the CPU list parser's result stream.
// Depends on clmp_pkg; bound to cpu_list_to_mask_parser at the end of this file.
module clmp_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           pop,
    input logic           empty,
    input clmp_pkg::out_t result
);

    // A waiting result that is not taken stays as it is.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed or vanished while stalled");

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> empty)
        else $error("result shown during reset");

    // A failed string gives one bare result.
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.status != clmp_pkg::ST_OK)) |->
        (result.last_result && (result.cpu_count == '0) && (result.highest_cpu == '0) &&
         (result.word_index == '0) && (result.mask_word == '0)))
        else $error("error result carries mask data");

    // Mask words of one string come in order with the same summary.
    a_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && $past(pop && !empty && !result.last_result)) |->
        ((result.word_index == ($past(result.word_index) + 4'd1)) &&
         (result.status == $past(result.status)) &&
         (result.cpu_count == $past(result.cpu_count)) &&
         (result.highest_cpu == $past(result.highest_cpu))))
        else $error("mask word out of sequence");

endmodule

bind cpu_list_to_mask_parser clmp_checker u_clmp_checker (.*);
